### rtl/ffbp_pkg.sv
// ----------------------------------------------------------------------------
// ffbp_pkg: shared types and constants for first-fit bin placement
// Field widths, item and register codes, and the controller/datapath structs.
// ----------------------------------------------------------------------------
package ffbp_pkg;

  // Field widths of the request and result items.
  localparam int MODE_W   = 1;
  localparam int BINF_W   = 3;
  localparam int SIZE_W   = 16;
  localparam int FILL_W   = 17;
  localparam int FACTOR_W = 9;
  localparam int OC_W     = 8;

  // Product widths of the two limit multiplications.
  localparam int PROD1_W = SIZE_W + FACTOR_W;
  localparam int PROD2_W = PROD1_W + FACTOR_W;

  // Q1.8 unity and the largest fill that a bin can report.
  localparam logic [FACTOR_W-1:0] Q8_ONE   = 9'd256;
  localparam logic [FILL_W-1:0]   FILL_MAX = 17'h1FFFF;

  // Request modes.
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_PLACE = 1'b1;

  // Register select, taken from the word address of the APB port.
  localparam logic REG_LIMIT_FACTOR = 1'b0;
  localparam logic REG_OVERCOMMIT   = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;      // latch the accepted request
    logic scan_start;   // reset the scan pointers
    logic mul1;         // avail * factor
    logic mul2;         // product * (1 + overcommit)
    logic ld_write;     // write the new limit and clear usage
    logic scan_step;    // issue one bin read and advance
    logic scan_commit;  // update the hit bin and record the result
    logic scan_miss;    // record a no-fit result
    logic res_load;     // move the result into the output register
  } ffbp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;        // the bin under check fits the item
    logic miss;       // all bins checked, none fits
    logic out_busy;   // output register holds a result not yet taken
  } ffbp_status_t;

endpackage

### rtl/ffbp_in_if.sv
// ----------------------------------------------------------------------------
// ffbp_in_if: request channel
// Valid/ready channel carrying one load or place request.
// ----------------------------------------------------------------------------
interface ffbp_in_if import ffbp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [BINF_W-1:0] bin_index;
  logic [SIZE_W-1:0] capacity;
  logic [SIZE_W-1:0] reserved;
  logic [SIZE_W-1:0] item_size;

  modport source (output valid, mode, bin_index, capacity, reserved, item_size,
                  input ready);
  modport sink   (input valid, mode, bin_index, capacity, reserved, item_size,
                  output ready);
endinterface

### rtl/ffbp_out_if.sv
// ----------------------------------------------------------------------------
// ffbp_out_if: result channel
// Valid/ready channel carrying one placement result.
// ----------------------------------------------------------------------------
interface ffbp_out_if import ffbp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              placed;
  logic [BINF_W-1:0] chosen_bin;
  logic [FILL_W-1:0] bin_fill;

  modport source (output valid, placed, chosen_bin, bin_fill, input ready);
  modport sink   (input valid, placed, chosen_bin, bin_fill, output ready);
endinterface

### rtl/first_fit_bin_placement.sv
// ----------------------------------------------------------------------------
// first_fit_bin_placement: first-fit placement of items into bins
// A request either loads one bin's limit or places an item in the first bin
// that still has room. One result is returned per request.
//
// Usage: requests enter on in_ch (valid/ready), results leave on out_ch.
// A load request (mode 0) computes the bin limit in two multiplier stages;
// the controller steps through MUL1, MUL2, the table write and the result
// state, and the next request is taken once it is back in idle. A place
// request scans the bin table in RAM, one bin read per cycle. The scan stops
// at the first bin that fits, or when all NUM_BINS bins are checked and none
// fits, and the next request is taken after the result state. The scan over
// the single RAM read port sets how fast place requests are taken.
// One request is in flight at a time; the result sits in an output register,
// so the next request is taken while a result waits on a stalled receiver.
// A second result waits inside until the output register drains.
// Reset clears the per-bin valid bits, so every bin reads as limit 0 and
// usage 0 right away; no clearing pass is needed. The limit factor resets to
// 1.0 and the overcommit ratio to 0. The user must write registers through
// the APB port only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module first_fit_bin_placement import ffbp_pkg::*; #(
  parameter int NUM_BINS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  ffbp_in_if.sink     in_ch,
  ffbp_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  ffbp_cmd_t           cmd;
  ffbp_status_t        status;
  logic [FACTOR_W-1:0] limit_factor;
  logic [OC_W-1:0]     overcommit_ratio;
  logic                in_ready;

  // Configuration registers.
  ffbp_cfg u_cfg (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .limit_factor     (limit_factor),
    .overcommit_ratio (overcommit_ratio)
  );

  // Controller.
  ffbp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_mode  (in_ch.mode),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  assign in_ch.ready = in_ready;

  // Datapath.
  ffbp_dp #(
    .NUM_BINS (NUM_BINS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .limit_factor     (limit_factor),
    .overcommit_ratio (overcommit_ratio),
    .in_bin_index     (in_ch.bin_index),
    .in_capacity      (in_ch.capacity),
    .in_reserved      (in_ch.reserved),
    .in_item_size     (in_ch.item_size),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_placed       (out_ch.placed),
    .out_chosen_bin   (out_ch.chosen_bin),
    .out_bin_fill     (out_ch.bin_fill)
  );

endmodule

### rtl/ffbp_ram.sv
// ----------------------------------------------------------------------------
// ffbp_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents have no reset.
// ----------------------------------------------------------------------------
module ffbp_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/ffbp_cfg.sv
// ----------------------------------------------------------------------------
// ffbp_cfg: configuration registers
// APB-style port holding the limit factor and the overcommit ratio.
// ----------------------------------------------------------------------------
module ffbp_cfg import ffbp_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output logic [FACTOR_W-1:0] limit_factor,
  output logic [OC_W-1:0]     overcommit_ratio
);

  logic [FACTOR_W-1:0] factor_r;
  logic [OC_W-1:0]     oc_r;
  logic                wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Register writes in the access cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factor_r <= Q8_ONE;
      oc_r     <= '0;
    end else if (wr_en) begin
      case (paddr[2])
        REG_LIMIT_FACTOR: factor_r <= pwdata[FACTOR_W-1:0];
        REG_OVERCOMMIT:   oc_r     <= pwdata[OC_W-1:0];
        default:          factor_r <= factor_r;
      endcase
    end
  end

  // Read-back of the selected register.
  always_comb begin
    case (paddr[2])
      REG_LIMIT_FACTOR: prdata = 32'(factor_r);
      REG_OVERCOMMIT:   prdata = 32'(oc_r);
      default:          prdata = '0;
    endcase
  end

  assign limit_factor     = factor_r;
  assign overcommit_ratio = oc_r;

endmodule

### rtl/ffbp_dp.sv
// ----------------------------------------------------------------------------
// ffbp_dp: placement datapath
// Limit multiplier chain, bin table in RAM, first-fit scan and result regs.
// ----------------------------------------------------------------------------
module ffbp_dp import ffbp_pkg::*; #(
  parameter int NUM_BINS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ffbp_cmd_t           cmd,
  output ffbp_status_t        status,
  input  logic [FACTOR_W-1:0] limit_factor,
  input  logic [OC_W-1:0]     overcommit_ratio,
  input  logic [BINF_W-1:0]   in_bin_index,
  input  logic [SIZE_W-1:0]   in_capacity,
  input  logic [SIZE_W-1:0]   in_reserved,
  input  logic [SIZE_W-1:0]   in_item_size,
  input  logic                out_ready,
  output logic                out_valid,
  output logic                out_placed,
  output logic [BINF_W-1:0]   out_chosen_bin,
  output logic [FILL_W-1:0]   out_bin_fill
);

  localparam int IDX_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int CNT_W = $clog2(NUM_BINS + 1);
  localparam int ENT_W = 2 * FILL_W;

  // Captured request.
  logic [BINF_W-1:0] idx_r;
  logic [SIZE_W-1:0] cap_r, res_r, size_r;

  // Limit arithmetic.
  logic [SIZE_W-1:0]   avail;
  logic [FACTOR_W-1:0] oc_scale;
  logic [PROD1_W-1:0]  p1_r;
  logic [PROD2_W-1:0]  p2_r;
  logic [FILL_W-1:0]   lim_sat;

  // Bin table.
  logic [NUM_BINS-1:0] valid_r;
  logic                ram_we, ram_re;
  logic [IDX_W-1:0]    ram_waddr, ram_raddr;
  logic [ENT_W-1:0]    ram_wdata, ram_rdata;

  // Scan pointers.
  logic [CNT_W-1:0] rd_cnt_r;
  logic             rd_more;
  logic             chk_vld_r;
  logic [IDX_W-1:0] chk_idx_r;
  logic             ent_vld_r;
  logic [FILL_W-1:0] ent_lim, ent_use;
  logic [FILL_W:0]   sum;
  logic              fit;

  // Load address decode.
  logic [31:0]      idx_ext, chk_ext;
  logic             ld_in_range;
  logic [IDX_W-1:0] ld_addr;

  // Result and output registers.
  logic              res_placed_r;
  logic [BINF_W-1:0] res_bin_r;
  logic [FILL_W-1:0] res_fill_r;
  logic              out_valid_r, out_placed_r;
  logic [BINF_W-1:0] out_bin_r;
  logic [FILL_W-1:0] out_fill_r;

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      idx_r  <= in_bin_index;
      cap_r  <= in_capacity;
      res_r  <= in_reserved;
      size_r <= in_item_size;
    end
  end

  // Limit = floor(avail * factor * (256 + overcommit) / 65536), in two stages.
  assign avail    = (cap_r > res_r) ? (cap_r - res_r) : '0;
  assign oc_scale = Q8_ONE + FACTOR_W'(overcommit_ratio);

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      p1_r <= PROD1_W'(avail) * PROD1_W'(limit_factor);
    end
    if (cmd.mul2) begin
      p2_r <= PROD2_W'(p1_r) * PROD2_W'(oc_scale);
    end
  end

  assign lim_sat = p2_r[PROD2_W-1] ? FILL_MAX : p2_r[PROD2_W-2:PROD2_W-1-FILL_W];

  // Load target; indexes past the last bin are dropped.
  assign idx_ext     = 32'(idx_r);
  assign ld_in_range = idx_ext < NUM_BINS;
  assign ld_addr     = idx_ext[IDX_W-1:0];

  // Scan read side: one bin read per cycle.
  assign rd_more   = rd_cnt_r < CNT_W'(NUM_BINS);
  assign ram_re    = cmd.scan_step && rd_more;
  assign ram_raddr = rd_cnt_r[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_cnt_r  <= '0;
      chk_vld_r <= 1'b0;
    end else if (cmd.scan_start) begin
      rd_cnt_r  <= '0;
      chk_vld_r <= 1'b0;
    end else if (cmd.scan_step) begin
      if (rd_more) begin
        rd_cnt_r <= rd_cnt_r + CNT_W'(1);
      end
      chk_vld_r <= rd_more;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      chk_idx_r <= ram_raddr;
      ent_vld_r <= valid_r[ram_raddr];
    end
  end

  // Fit check on the entry just read; a never-loaded bin reads as zero.
  assign ent_lim = ent_vld_r ? ram_rdata[ENT_W-1:FILL_W] : '0;
  assign ent_use = ent_vld_r ? ram_rdata[FILL_W-1:0] : '0;
  assign sum     = (FILL_W + 1)'(ent_use) + (FILL_W + 1)'(size_r);
  assign fit     = sum <= {1'b0, ent_lim};

  assign status.hit      = chk_vld_r && fit;
  assign status.miss     = !chk_vld_r && !rd_more;
  assign status.out_busy = out_valid_r && !out_ready;

  // Table write: a load sets the limit and clears usage, a hit adds the item.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = chk_idx_r;
    ram_wdata = {ent_lim, sum[FILL_W-1:0]};
    if (cmd.ld_write) begin
      ram_we    = ld_in_range;
      ram_waddr = ld_addr;
      ram_wdata = {lim_sat, {FILL_W{1'b0}}};
    end else if (cmd.scan_commit) begin
      ram_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ram_we) begin
      valid_r[ram_waddr] <= 1'b1;
    end
  end

  ffbp_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_BINS)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Result of the current request.
  assign chk_ext = 32'(chk_idx_r);

  always_ff @(posedge clk) begin
    if (cmd.ld_write) begin
      res_placed_r <= 1'b0;
      res_bin_r    <= idx_r;
      res_fill_r   <= '0;
    end else if (cmd.scan_commit) begin
      res_placed_r <= 1'b1;
      res_bin_r    <= chk_ext[BINF_W-1:0];
      res_fill_r   <= sum[FILL_W-1:0];
    end else if (cmd.scan_miss) begin
      res_placed_r <= 1'b0;
      res_bin_r    <= '0;
      res_fill_r   <= '0;
    end
  end

  // Output register toward the result channel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_placed_r <= res_placed_r;
      out_bin_r    <= res_bin_r;
      out_fill_r   <= res_fill_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_placed     = out_placed_r;
  assign out_chosen_bin = out_bin_r;
  assign out_bin_fill   = out_fill_r;

endmodule

### rtl/ffbp_ctrl.sv
// ----------------------------------------------------------------------------
// ffbp_ctrl: placement controller
// Sequences a load through the multiplier chain or a place through the scan.
// ----------------------------------------------------------------------------
module ffbp_ctrl import ffbp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic         in_mode,
  output logic         in_ready,
  input  ffbp_status_t status,
  output ffbp_cmd_t    cmd
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL1 = 6'b000010,
    S_MUL2 = 6'b000100,
    S_LDWR = 6'b001000,
    S_SCAN = 6'b010000,
    S_RES  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready = state_r == S_IDLE;
  assign accept   = in_ready && in_valid;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          if (in_mode == MODE_PLACE) begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_SCAN;
          end else begin
            state_nxt = S_MUL1;
          end
        end
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_LDWR;
      end
      S_LDWR: begin
        cmd.ld_write = 1'b1;
        state_nxt    = S_RES;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.hit) begin
          cmd.scan_commit = 1'b1;
          state_nxt       = S_RES;
        end else if (status.miss) begin
          cmd.scan_miss = 1'b1;
          state_nxt     = S_RES;
        end
      end
      S_RES: begin
        if (!status.out_busy) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
